/* rtl/assert_macros.svh */
// assertion macros, sampled on clk and disabled while rst is high
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/s2dec_pkg.sv */
`default_nettype none
package s2dec_pkg;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned DIGIT_W = 4;

  localparam logic [CHAR_W-1:0]  CHAR_MINUS = 8'd45;
  localparam logic [CHAR_W-1:0]  CHAR_ZERO  = 8'd48;
  localparam logic [DIGIT_W-1:0] DIGIT_MAX  = 4'd9;
  localparam logic [DIGIT_W-1:0] BCD_FIX_AT = 4'd5;
  localparam logic [DIGIT_W-1:0] BCD_FIX    = 4'd3;

endpackage
`default_nettype wire

/* rtl/signed_int_to_decimal_ascii_unit.sv */
// operation: after the item is taken, shift-and-add-3 conversion of the magnitude,
//   then dropping leading zeros, then loading the first character,
//   then one character per cycle while m_tready is high
// the bit-serial double-dabble loop and the character output keep the block busy; it takes
//   no new value until the last character of the previous one has been accepted
// reset: synchronous active-high rst returns the sequencer to idle and drops m_tvalid
`default_nettype none
module signed_int_to_decimal_ascii_unit #(
  parameter int unsigned VALUE_BITS = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  input  wire logic [s2dec_pkg::VALUE_W-1:0] s_tdata,  // [31:0] value
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic [s2dec_pkg::CHAR_W-1:0]       m_tdata,  // [7:0] char_code
  output logic                               m_tlast   // is_last
);
  import s2dec_pkg::*;

  // decimal digits needed for a VALUE_BITS-bit magnitude
  localparam int unsigned NDIG   = ((VALUE_BITS * 1233) >> 12) + 1;
  localparam int unsigned BCD_W  = NDIG * DIGIT_W;
  localparam int unsigned EXT_W  = (VALUE_BITS > VALUE_W) ? VALUE_BITS : VALUE_W;
  localparam int unsigned CNT_W  = $clog2(VALUE_BITS);
  localparam int unsigned LEFT_W = $clog2(NDIG + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_SIGN,
    ST_DIGIT
  } state_t;

  state_t                  state;
  logic [VALUE_BITS-1:0]   mag;
  logic [BCD_W-1:0]        bcd;
  logic [CNT_W-1:0]        cnt;
  logic [LEFT_W-1:0]       left;
  logic                    neg;

  logic [EXT_W-1:0]        in_ext;
  logic [VALUE_BITS-1:0]   in_val;
  logic [BCD_W-1:0]        bcd_adj;
  logic [BCD_W-1:0]        bcd_next;
  logic [DIGIT_W-1:0]      top_digit;
  logic [DIGIT_W-1:0]      second_digit;

  assign in_ext       = EXT_W'(s_tdata);
  assign in_val       = in_ext[VALUE_BITS-1:0];
  assign top_digit    = bcd[BCD_W-1 -: DIGIT_W];
  assign second_digit = bcd[BCD_W-DIGIT_W-1 -: DIGIT_W];
  assign s_tready     = (state == ST_IDLE);

  // add-3 correction, every digit corrected in parallel
  always_comb begin
    for (int d = 0; d < NDIG; d++) begin
      if (bcd[d*DIGIT_W +: DIGIT_W] >= BCD_FIX_AT) begin
        bcd_adj[d*DIGIT_W +: DIGIT_W] = bcd[d*DIGIT_W +: DIGIT_W] + BCD_FIX;
      end else begin
        bcd_adj[d*DIGIT_W +: DIGIT_W] = bcd[d*DIGIT_W +: DIGIT_W];
      end
    end
    bcd_next = {bcd_adj[BCD_W-2:0], mag[VALUE_BITS-1]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            neg   <= in_val[VALUE_BITS-1];
            mag   <= in_val[VALUE_BITS-1] ? (~in_val + 1'b1) : in_val;
            bcd   <= '0;
            cnt   <= CNT_W'(VALUE_BITS - 1);
            state <= ST_CONV;
          end
        end
        ST_CONV: begin
          bcd <= bcd_next;
          mag <= {mag[VALUE_BITS-2:0], 1'b0};
          cnt <= cnt - 1'b1;
          if (cnt == '0) begin
            left  <= LEFT_W'(NDIG);
            state <= ST_SKIP;
          end
        end
        ST_SKIP: begin
          // drop leading zeros, keep at least one digit
          if (top_digit == '0 && left != LEFT_W'(1)) begin
            bcd  <= {bcd[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
            left <= left - 1'b1;
          end else if (neg) begin
            m_tvalid <= 1'b1;
            m_tdata  <= CHAR_MINUS;
            m_tlast  <= 1'b0;
            state    <= ST_SIGN;
          end else begin
            m_tvalid <= 1'b1;
            m_tdata  <= CHAR_ZERO + CHAR_W'(top_digit);
            m_tlast  <= (left == LEFT_W'(1));
            state    <= ST_DIGIT;
          end
        end
        ST_SIGN: begin
          if (m_tready) begin
            m_tdata <= CHAR_ZERO + CHAR_W'(top_digit);
            m_tlast <= (left == LEFT_W'(1));
            state   <= ST_DIGIT;
          end
        end
        ST_DIGIT: begin
          if (m_tready) begin
            if (m_tlast) begin
              m_tvalid <= 1'b0;
              state    <= ST_IDLE;
            end else begin
              bcd     <= {bcd[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
              left    <= left - 1'b1;
              m_tdata <= CHAR_ZERO + CHAR_W'(second_digit);
              m_tlast <= (left == LEFT_W'(2));
            end
          end
        end
        default: begin
          m_tvalid <= 1'b0;
          state    <= ST_IDLE;
        end
      endcase
    end
  end

`include "assert_macros.svh"

  `ASSERT_SAME(a_busy_excl, s_tready, !m_tvalid, "input taken while a character is pending")
  `ASSERT_NEXT(a_take_busy, s_tvalid && s_tready, !s_tready, "ready held after taking an item")
  `ASSERT_SAME(a_sign_first, m_tvalid && m_tdata == CHAR_MINUS, !m_tlast, "sign flagged as last")
  `ASSERT_SAME(a_digit_rng, m_tvalid && m_tdata != CHAR_MINUS, (m_tdata >= CHAR_ZERO) && (m_tdata <= CHAR_ZERO + CHAR_W'(DIGIT_MAX)), "character is not a decimal digit")

endmodule
`default_nettype wire

/* test/decimal_text_checker.sv */
`timescale 1ns / 1ps
module decimal_text_checker
  import s2dec_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  input  logic               s_tready,
  input  logic [VALUE_W-1:0] s_tdata,
  input  logic               m_tvalid,
  input  logic               m_tready,
  input  logic [CHAR_W-1:0]  m_tdata,
  input  logic               m_tlast,
  output int                 errors,
  output int                 pending
);

  typedef struct packed {
    logic [CHAR_W-1:0] code;
    logic              is_last;
  } text_char_t;

  text_char_t text_q[$];

  // decimal text of one value, most significant character first
  function automatic void queue_text(input logic [VALUE_W-1:0] value);
    logic [VALUE_W:0]   mag;
    logic [DIGIT_W-1:0] digs[0:19];
    int                 n;
    logic               neg;
    neg = value[VALUE_W-1];
    // one extra bit so the most negative value keeps its magnitude
    mag = neg ? ({1'b0, ~value} + 1'b1) : {1'b0, value};
    n = 0;
    do begin
      digs[n] = DIGIT_W'(mag % 10);
      n++;
      mag = mag / 10;
    end while (mag != 0);
    if (neg) text_q.push_back('{CHAR_MINUS, 1'b0});
    for (int k = n - 1; k >= 0; k--)
      text_q.push_back('{CHAR_ZERO + CHAR_W'(digs[k]), k == 0});
  endfunction

  always @(posedge clk) begin
    text_char_t want;
    if (rst) begin
      text_q.delete();
      errors <= 0;
    end else begin
      if (s_tvalid && s_tready) queue_text(s_tdata);
      if (m_tvalid && m_tready) begin
        if (text_q.size() == 0) begin
          $error("char_code %0d arrived with no character expected", m_tdata);
          errors <= errors + 1;
        end else begin
          want = text_q.pop_front();
          if (m_tdata !== want.code) begin
            $error("char_code: expected %0d, got %0d", want.code, m_tdata);
            errors <= errors + 1;
          end else if (m_tlast !== want.is_last) begin
            $error("is_last: expected %0b, got %0b", want.is_last, m_tlast);
            errors <= errors + 1;
          end
        end
      end
    end
    pending <= text_q.size();
  end

endmodule

/* test/signed_int_to_decimal_ascii_unit_tb.sv */
`timescale 1ns / 1ps
module signed_int_to_decimal_ascii_unit_tb;
  import s2dec_pkg::*;

  localparam int N_RANDOM    = 270;
  localparam int N_CALM      = 40;
  localparam int CYCLE_LIMIT = 200000;
  localparam int LONG_HOLD   = 400;

  logic               clk = 1'b0;
  logic               rst;
  logic               s_tvalid;
  logic               s_tready;
  logic [VALUE_W-1:0] s_tdata;
  logic               m_tvalid;
  logic               m_tready;
  logic [CHAR_W-1:0]  m_tdata;
  logic               m_tlast;
  int                 errors;
  int                 pending;
  int                 cycles = 0;
  bit                 calm = 1'b0;
  bit                 hold_req = 1'b0;
  bit                 hold_done = 1'b0;

  always #1 clk = ~clk;

  signed_int_to_decimal_ascii_unit u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  decimal_text_checker u_checker (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .errors   (errors),
    .pending  (pending)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // character sink: random stalls, one long hold-off on request
  initial begin
    m_tready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req && !hold_done) begin
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_done = 1'b1;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  task automatic push_value(input logic [VALUE_W-1:0] value);
    s_tdata  <= value;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic source_gap(input int n);
    s_tvalid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    @(posedge clk);
  endtask

  // magnitudes spread over all digit counts, either sign
  function automatic logic [VALUE_W-1:0] pick_value();
    logic [VALUE_W-1:0] v;
    case ($urandom_range(0, 5))
      0:       v = $urandom;
      1:       v = $urandom_range(0, 9);
      2:       v = {1'b1, 31'($urandom_range(0, 3))};
      default: begin
        v = $urandom >> $urandom_range(1, 31);
        if ($urandom_range(0, 1)) v = -v;
      end
    endcase
    return v;
  endfunction

  logic [VALUE_W-1:0] directed[$] = '{
    32'd0, 32'd1, -32'sd1, 32'd9, 32'd10, -32'sd10, 32'd99, 32'd100, -32'sd100,
    32'h7fffffff, 32'h80000000, 32'h80000001, 32'd1000000000, 32'd999999999,
    -32'sd999999999, 32'd1234567890, -32'sd1234567890, 32'h55555555,
    32'haaaaaaaa, 32'h0000ffff, 32'hffff0000, -32'sd9
  };

  initial begin
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i]) begin
      push_value(directed[i]);
      if ($urandom_range(0, 2) == 0) source_gap($urandom_range(1, 5));
    end

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == 60) hold_req = 1'b1;
      if (i == 150) begin
        s_tvalid <= 1'b0;
        wait_drained();
      end
      if (i == N_RANDOM - N_CALM) calm = 1'b1;
      push_value(pick_value());
      if (!calm && $urandom_range(0, 3) == 0) source_gap($urandom_range(1, 5));
    end

    s_tvalid <= 1'b0;
    wait_drained();
    repeat (80) @(posedge clk);
    if (errors == 0 && pending == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl
rtl/s2dec_pkg.sv
rtl/signed_int_to_decimal_ascii_unit.sv
test/decimal_text_checker.sv
test/signed_int_to_decimal_ascii_unit_tb.sv
